@@ rtl/core/swipe_gesture_recognizer_assert.svh @@
// Assertion macros used by the swipe recognizer checker.
`ifndef SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH
`define SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swipe checker: same-cycle rule violated");

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swipe checker: next-cycle rule violated");

`endif

@@ rtl/core/sgr_pkg.sv @@
// Shared types, constants and the threshold function of the swipe recognizer.
`timescale 1ns / 1ps

package sgr_pkg;

  localparam int SAMPLES     = 10;
  localparam int MAX_SAMPLES = 10;
  localparam int SPAN        = SAMPLES - 1;

  localparam int SMP_W  = 8;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = 6;
  localparam int TIME_W = 48;
  localparam int HOLD_W = 24;
  localparam int CFG_W  = 24;
  localparam int DEN_W  = 7;   // SPAN * count, at most 90
  localparam int PROD_W = 13;  // index sum times denominator
  localparam int DL_W   = 11;  // delta times denominator
  localparam int RHS_W  = 18;  // delta times both denominators
  localparam int MAG_W  = 17;  // ten times the cross-product difference

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_TRACK = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_t;

  localparam logic [1:0] REG_ARM_COUNT    = 2'd0;
  localparam logic [1:0] REG_TRACK_COUNT  = 2'd1;
  localparam logic [1:0] REG_DELTA_TENTHS = 2'd2;
  localparam logic [1:0] REG_HOLDOFF_US   = 2'd3;

  localparam logic [CNT_W-1:0]  ARM_COUNT_RST    = 4'd1;
  localparam logic [CNT_W-1:0]  TRACK_COUNT_RST  = 4'd3;
  localparam logic [CNT_W-1:0]  DELTA_TENTHS_RST = 4'd4;
  localparam logic [HOLD_W-1:0] HOLDOFF_US_RST   = 24'd300000;

  localparam longint COEF_SCALE = 64'sd10000000000;
  localparam longint LIT_SCALE  = 64'sd204;

  typedef longint coef_arr_t [7];
  localparam coef_arr_t VIG_COEF = '{
    64'sd5100000000, 64'sd20850000079, -64'sd22920000933, -64'sd54449996093,
    64'sd175499992571, -64'sd178199993450, 64'sd58319997827
  };

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic cmp;
    logic commit;
  } sgr_cmd_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             swipe_found;
    logic             swipe_down;
    logic [CNT_W-1:0] lit_count;
    logic [IDX_W-1:0] index_sum;
  } sgr_result_t;

  // Brightness level a sample must exceed at position pos, evaluated at
  // elaboration. The byte range is scanned for the lowest lit level, so -1
  // means always lit and 255 never lit.
  function automatic logic signed [9:0] lit_threshold(input int pos);
    longint dpw [7];
    longint ipow;
    longint acc;
    longint num;
    longint den;
    longint q;
    dpw[0] = 1;
    for (int k = 1; k < 7; k++) begin
      dpw[k] = dpw[k-1] * SPAN;
    end
    ipow = 1;
    acc  = 0;
    for (int k = 0; k < 7; k++) begin
      acc  = acc + VIG_COEF[k] * ipow * dpw[6-k];
      ipow = ipow * pos;
    end
    num = LIT_SCALE * acc;
    den = COEF_SCALE * dpw[6];
    q   = 255;
    for (int s = 255; s >= 0; s--) begin
      if (longint'(s) * den > num) begin
        q = s - 1;
      end
    end
    return signed'(q[9:0]);
  endfunction

endpackage

@@ rtl/core/sgr_ifs.sv @@
// Valid/ready channel interfaces for frames in and reports out.
`timescale 1ns / 1ps

interface swipe_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sample_0;
  logic [7:0]  sample_1;
  logic [7:0]  sample_2;
  logic [7:0]  sample_3;
  logic [7:0]  sample_4;
  logic [7:0]  sample_5;
  logic [7:0]  sample_6;
  logic [7:0]  sample_7;
  logic [7:0]  sample_8;
  logic [7:0]  sample_9;
  logic [47:0] timestamp_us;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9, timestamp_us,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9, timestamp_us,
    output ready
  );
endinterface

interface swipe_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       swipe_found;
  logic       swipe_down;
  logic [3:0] lit_count;
  logic [5:0] index_sum;

  modport source (
    output valid, mode, swipe_found, swipe_down, lit_count, index_sum,
    input  ready
  );
  modport sink (
    input  valid, mode, swipe_found, swipe_down, lit_count, index_sum,
    output ready
  );
endinterface

@@ rtl/core/sgr_ctrl.sv @@
// Sequencer: steps each frame through capture, two arithmetic steps and commit.
`timescale 1ns / 1ps

module sgr_ctrl
  import sgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sgr_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state;
  logic   can_load;

  assign in_ready = (state == ST_WAIT);
  // The report register may be reloaded when empty or when drained this cycle.
  assign can_load = !out_valid || out_ready;

  assign cmd.capture = in_valid && in_ready;
  assign cmd.mul     = (state == ST_MUL);
  assign cmd.cmp     = (state == ST_CMP);
  assign cmd.commit  = (state == ST_DONE) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_WAIT: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (can_load) begin
            state <= ST_WAIT;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sgr_dp.sv @@
// Datapath: thresholds, mass and index sum, centroid cross-product, gesture mode.
`timescale 1ns / 1ps

module sgr_dp
  import sgr_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  sgr_cmd_t                           cmd,
  input  logic [MAX_SAMPLES-1:0][SMP_W-1:0]  frame_samples,
  input  logic [TIME_W-1:0]                  frame_time,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data,
  output sgr_result_t                        result
);

  // Configuration registers.
  logic [CNT_W-1:0]  arm_count;
  logic [CNT_W-1:0]  track_count;
  logic [CNT_W-1:0]  delta_tenths;
  logic [HOLD_W-1:0] holdoff_us;

  // Gesture state.
  mode_t             mode_reg;
  logic [IDX_W-1:0]  start_sum;
  logic [CNT_W-1:0]  start_count;
  logic [IDX_W-1:0]  last_sum;
  logic [CNT_W-1:0]  last_count;
  logic [TIME_W-1:0] holdoff_end;

  // Per-frame working registers.
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  sum;
  logic [TIME_W-1:0] now;
  logic [PROD_W-1:0] prod_ls;
  logic [PROD_W-1:0] prod_sl;
  logic [DL_W-1:0]   prod_dl;
  logic [DEN_W-1:0]  sden_q;
  logic [MAG_W-1:0]  mag10;
  logic [RHS_W-1:0]  rhs;
  logic              diff_pos;

  logic [SAMPLES-1:0] lit;
  logic [CNT_W-1:0]   cnt_c;
  logic [IDX_W-1:0]   sum_c;

  logic [IDX_W-1:0]  lnum;
  logic [IDX_W-1:0]  snum;
  logic [DEN_W-1:0]  lden;
  logic [DEN_W-1:0]  sden;
  logic signed [PROD_W:0] diff;
  logic [PROD_W-1:0] mag;

  mode_t             mode_next;
  logic [IDX_W-1:0]  start_sum_next;
  logic [CNT_W-1:0]  start_count_next;
  logic [IDX_W-1:0]  last_sum_next;
  logic [CNT_W-1:0]  last_count_next;
  logic [TIME_W-1:0] holdoff_end_next;
  logic              found_next;
  logic              down_next;
  logic [TIME_W-1:0] elapsed;

  for (genvar g = 0; g < SAMPLES; g++) begin : g_thr
    localparam logic signed [9:0] THR = lit_threshold(g);
    assign lit[g] = $signed({2'b00, frame_samples[g]}) > THR;
  end

  always_comb begin
    cnt_c = '0;
    sum_c = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      if (lit[i]) begin
        cnt_c = cnt_c + CNT_W'(1);
        sum_c = sum_c + IDX_W'(i);
      end
    end
  end

  // Centroids are sum / (SPAN * count); an empty stored frame counts as 0 / 1.
  assign lnum = (last_count != '0) ? last_sum : '0;
  assign snum = (start_count != '0) ? start_sum : '0;
  assign lden = (last_count != '0) ? DEN_W'(SPAN) * DEN_W'(last_count) : DEN_W'(1);
  assign sden = (start_count != '0) ? DEN_W'(SPAN) * DEN_W'(start_count) : DEN_W'(1);

  assign diff = $signed({1'b0, prod_ls}) - $signed({1'b0, prod_sl});
  assign mag  = diff[PROD_W] ? PROD_W'(-diff) : diff[PROD_W-1:0];

  assign elapsed = now - holdoff_end;

  always_comb begin
    mode_next        = mode_reg;
    start_sum_next   = start_sum;
    start_count_next = start_count;
    last_sum_next    = last_sum;
    last_count_next  = last_count;
    holdoff_end_next = holdoff_end;
    found_next       = 1'b0;
    down_next        = 1'b0;
    unique case (mode_reg)
      MODE_IDLE: begin
        if (cnt >= arm_count) begin
          mode_next        = MODE_ARMED;
          start_sum_next   = sum;
          start_count_next = cnt;
          last_sum_next    = sum;
          last_count_next  = cnt;
        end
      end
      MODE_ARMED: begin
        if (cnt >= track_count) begin
          mode_next = MODE_TRACK;
        end else if (cnt < arm_count) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_TRACK: begin
        if (cnt < arm_count) begin
          if ({1'b0, mag10} > rhs) begin
            found_next       = 1'b1;
            down_next        = diff_pos;
            holdoff_end_next = now + TIME_W'(holdoff_us);
            mode_next        = MODE_HOLD;
          end else begin
            mode_next = MODE_IDLE;
          end
        end else begin
          last_sum_next   = sum;
          last_count_next = cnt;
        end
      end
      MODE_HOLD: begin
        // The end time is reached when the wrapped difference is non-negative.
        if (!elapsed[TIME_W-1]) begin
          mode_next = MODE_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_count    <= ARM_COUNT_RST;
      track_count  <= TRACK_COUNT_RST;
      delta_tenths <= DELTA_TENTHS_RST;
      holdoff_us   <= HOLDOFF_US_RST;
      mode_reg     <= MODE_IDLE;
      start_sum    <= '0;
      start_count  <= '0;
      last_sum     <= '0;
      last_count   <= '0;
      holdoff_end  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ARM_COUNT:    arm_count    <= cfg_data[CNT_W-1:0];
          REG_TRACK_COUNT:  track_count  <= cfg_data[CNT_W-1:0];
          REG_DELTA_TENTHS: delta_tenths <= cfg_data[CNT_W-1:0];
          REG_HOLDOFF_US:   holdoff_us   <= cfg_data[HOLD_W-1:0];
        endcase
      end
      if (cmd.commit) begin
        mode_reg    <= mode_next;
        start_sum   <= start_sum_next;
        start_count <= start_count_next;
        last_sum    <= last_sum_next;
        last_count  <= last_count_next;
        holdoff_end <= holdoff_end_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt <= cnt_c;
      sum <= sum_c;
      now <= frame_time;
    end
    if (cmd.mul) begin
      prod_ls <= PROD_W'(lnum) * PROD_W'(sden);
      prod_sl <= PROD_W'(snum) * PROD_W'(lden);
      prod_dl <= DL_W'(delta_tenths) * DL_W'(lden);
      sden_q  <= sden;
    end
    if (cmd.cmp) begin
      mag10    <= MAG_W'(mag) * MAG_W'(10);
      rhs      <= RHS_W'(prod_dl) * RHS_W'(sden_q);
      diff_pos <= !diff[PROD_W] && (diff != '0);
    end
    if (cmd.commit) begin
      result.mode        <= mode_next;
      result.swipe_found <= found_next;
      result.swipe_down  <= down_next;
      result.lit_count   <= cnt;
      result.index_sum   <= sum;
    end
  end

endmodule

@@ rtl/core/swipe_gesture_recognizer.sv @@
// Top level of the swipe gesture recognizer.
`timescale 1ns / 1ps

// Takes one frame word of ten brightness samples and a microsecond timestamp
// and returns one report word per frame: the gesture mode after the frame,
// whether a swipe was recognized and its direction, the lit count and the
// index sum. Between acceptance and the next frame being accepted, a frame is
// thresholded and counted, goes through the centroid cross-multiplication
// (products, then difference and scaled bound), and commits the mode once the
// output register is free. The report sits in an output register, so the next
// frame is accepted while an earlier report waits to be taken. Configuration
// writes go straight into the registers and should be made only while no
// frame is in progress.
module swipe_gesture_recognizer
  import sgr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  swipe_frame_if.sink          frame,
  swipe_report_if.source       report,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sgr_cmd_t                          cmd;
  sgr_result_t                       result;
  logic [MAX_SAMPLES-1:0][SMP_W-1:0] frame_samples;

  assign frame_samples[0] = frame.sample_0;
  assign frame_samples[1] = frame.sample_1;
  assign frame_samples[2] = frame.sample_2;
  assign frame_samples[3] = frame.sample_3;
  assign frame_samples[4] = frame.sample_4;
  assign frame_samples[5] = frame.sample_5;
  assign frame_samples[6] = frame.sample_6;
  assign frame_samples[7] = frame.sample_7;
  assign frame_samples[8] = frame.sample_8;
  assign frame_samples[9] = frame.sample_9;

  sgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (report.valid),
    .out_ready (report.ready),
    .cmd       (cmd)
  );

  sgr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .frame_samples (frame_samples),
    .frame_time    (frame.timestamp_us),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result        (result)
  );

  assign report.mode        = result.mode;
  assign report.swipe_found = result.swipe_found;
  assign report.swipe_down  = result.swipe_down;
  assign report.lit_count   = result.lit_count;
  assign report.index_sum   = result.index_sum;

endmodule

@@ rtl/core/sgr_checker.sv @@
// Port-level checker for the swipe recognizer, bound to the top level.
`timescale 1ns / 1ps
`include "swipe_gesture_recognizer_assert.svh"

module sgr_checker
  import sgr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mode,
  input logic       swipe_found,
  input logic       swipe_down,
  input logic [3:0] lit_count,
  input logic [5:0] index_sum
);

  // A stalled report word keeps its mode and index sum.
  `SGR_ASSERT_NEXT(a_report_held, out_valid && !out_ready, out_valid && $stable(index_sum) && $stable(mode))
  // A recognized swipe always leaves the block in holdoff.
  `SGR_ASSERT_NOW(a_swipe_holdoff, out_valid && swipe_found, mode == MODE_HOLD)
  // The direction bit is only set together with a swipe.
  `SGR_ASSERT_NOW(a_down_needs_swipe, out_valid && swipe_down, swipe_found)
  // The lit count never exceeds the number of positions.
  `SGR_ASSERT_NOW(a_count_range, out_valid, lit_count <= 4'(SAMPLES))
  // A frame is worked on in the states that follow its capture, so the block is busy right after taking one.
  `SGR_ASSERT_NEXT(a_busy_after_frame, in_valid && in_ready, !in_ready)

endmodule

bind swipe_gesture_recognizer sgr_checker u_sgr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (frame.valid),
  .in_ready    (frame.ready),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .mode        (report.mode),
  .swipe_found (report.swipe_found),
  .swipe_down  (report.swipe_down),
  .lit_count   (report.lit_count),
  .index_sum   (report.index_sum)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the swipe gesture recognizer.
`timescale 1ns / 1ps

module tb_top;
  import sgr_pkg::*;

  localparam int ITEMS_TARGET = 1400;
  localparam int PHASE_ITEMS  = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 40;
  localparam int JUNK_W       = CFG_W - CNT_W;
  localparam logic [TIME_W-1:0] TS_MAX = '1;

  typedef struct packed {
    logic [9:0][7:0]   smp;
    logic [TIME_W-1:0] ts;
  } frame_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  swipe_frame_if  frame_ch ();
  swipe_report_if report_ch ();

  swipe_gesture_recognizer dut (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and gesture state of the predictor.
  logic [CNT_W-1:0]  cfg_arm;
  logic [CNT_W-1:0]  cfg_track;
  logic [CNT_W-1:0]  cfg_delta;
  logic [HOLD_W-1:0] cfg_hold;
  mode_t             gm_mode;
  logic [IDX_W-1:0]  gm_start_sum;
  logic [IDX_W-1:0]  gm_last_sum;
  logic [CNT_W-1:0]  gm_start_cnt;
  logic [CNT_W-1:0]  gm_last_cnt;
  logic [TIME_W-1:0] gm_hold_end;

  sgr_result_t reports_pending[$];
  int          lit_level[10];
  int          errors;
  int          items_sent;
  int          reports_seen;
  int          swipes_down;
  int          swipes_up;
  int          phases_run;
  int          burst_left;
  int          hold_request;
  int          cycle_cnt;
  int unsigned ts_step_max;
  logic [TIME_W-1:0] ts_now;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("swipe_gesture_recognizer regression: fail");
      $finish;
    end
  end

  function automatic longint vig_coef(input int k);
    case (k)
      0: return 64'sd5100000000;
      1: return 64'sd20850000079;
      2: return -64'sd22920000933;
      3: return -64'sd54449996093;
      4: return 64'sd175499992571;
      5: return -64'sd178199993450;
      default: return 64'sd58319997827;
    endcase
  endfunction

  // Exact integer form of sample/255 > 0.8 * V(pos/SPAN).
  function automatic bit sample_lit(input int pos, input logic [7:0] s);
    longint dpow[7];
    longint ipow;
    longint acc;
    longint sv;
    dpow[0] = 1;
    for (int k = 1; k < 7; k++) dpow[k] = dpow[k-1] * SPAN;
    ipow = 1;
    acc  = 0;
    for (int k = 0; k < 7; k++) begin
      acc  = acc + vig_coef(k) * ipow * dpow[6-k];
      ipow = ipow * pos;
    end
    sv = s;
    return sv * 64'sd10000000000 * dpow[6] > 64'sd204 * acc;
  endfunction

  task automatic gesture_reset();
    cfg_arm      = ARM_COUNT_RST;
    cfg_track    = TRACK_COUNT_RST;
    cfg_delta    = DELTA_TENTHS_RST;
    cfg_hold     = HOLDOFF_US_RST;
    gm_mode      = MODE_IDLE;
    gm_start_sum = '0;
    gm_last_sum  = '0;
    gm_start_cnt = '0;
    gm_last_cnt  = '0;
    gm_hold_end  = '0;
  endtask

  function automatic sgr_result_t predict_report(input frame_t f);
    int cnt;
    int sum;
    longint lnum, snum, lden, sden, diff, mag;
    logic [TIME_W-1:0] since_end;
    sgr_result_t r;
    cnt = 0;
    sum = 0;
    r   = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      if (sample_lit(i, f.smp[i])) begin
        cnt++;
        sum += i;
      end
    end
    case (gm_mode)
      MODE_IDLE: begin
        if (cnt >= cfg_arm) begin
          gm_mode      = MODE_ARMED;
          gm_start_sum = IDX_W'(sum);
          gm_start_cnt = CNT_W'(cnt);
          gm_last_sum  = IDX_W'(sum);
          gm_last_cnt  = CNT_W'(cnt);
        end
      end
      MODE_ARMED: begin
        if (cnt >= cfg_track) gm_mode = MODE_TRACK;
        else if (cnt < cfg_arm) gm_mode = MODE_IDLE;
      end
      MODE_TRACK: begin
        if (cnt < cfg_arm) begin
          // Centroids are compared by cross-multiplication; an empty stored
          // frame counts as centroid zero over a denominator of one.
          lnum = (gm_last_cnt != 0) ? gm_last_sum : 0;
          snum = (gm_start_cnt != 0) ? gm_start_sum : 0;
          lden = (gm_last_cnt != 0) ? SPAN * gm_last_cnt : 1;
          sden = (gm_start_cnt != 0) ? SPAN * gm_start_cnt : 1;
          diff = lnum * sden - snum * lden;
          mag  = (diff < 0) ? -diff : diff;
          if (10 * mag > longint'(cfg_delta) * lden * sden) begin
            r.swipe_found = 1'b1;
            r.swipe_down  = (diff > 0);
            gm_hold_end   = f.ts + TIME_W'(cfg_hold);
            gm_mode       = MODE_HOLD;
          end else begin
            gm_mode = MODE_IDLE;
          end
        end else begin
          gm_last_sum = IDX_W'(sum);
          gm_last_cnt = CNT_W'(cnt);
        end
      end
      default: begin
        since_end = f.ts - gm_hold_end;
        if (!since_end[TIME_W-1]) gm_mode = MODE_IDLE;
      end
    endcase
    r.mode      = gm_mode;
    r.lit_count = CNT_W'(cnt);
    r.index_sum = IDX_W'(sum);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("report %0d at %0t: %s is %0d, expected %0d", reports_seen, $time, field,
               got, want);
  endtask

  task automatic check_report(input sgr_result_t want, input sgr_result_t got);
    if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
    if (got.swipe_found !== want.swipe_found)
      report_mismatch("swipe_found", got.swipe_found, want.swipe_found);
    if (got.swipe_down !== want.swipe_down)
      report_mismatch("swipe_down", got.swipe_down, want.swipe_down);
    if (got.lit_count !== want.lit_count)
      report_mismatch("lit_count", got.lit_count, want.lit_count);
    if (got.index_sum !== want.index_sum)
      report_mismatch("index_sum", got.index_sum, want.index_sum);
  endtask

  always @(posedge clk) begin
    sgr_result_t got;
    sgr_result_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      got.mode        = report_ch.mode;
      got.swipe_found = report_ch.swipe_found;
      got.swipe_down  = report_ch.swipe_down;
      got.lit_count   = report_ch.lit_count;
      got.index_sum   = report_ch.index_sum;
      if (reports_pending.size() == 0) begin
        report_mismatch("report word with no frame pending, mode", got.mode, 0);
      end else begin
        want = reports_pending.pop_front();
        check_report(want, got);
        if (want.swipe_found) begin
          if (want.swipe_down) swipes_down++;
          else swipes_up++;
        end
      end
      reports_seen++;
    end
  end

  // Receiver: changes its stall style now and then, and honors a requested
  // long hold-off that it counts down itself.
  initial begin : receiver
    int stall_left;
    int style;
    int style_left;
    int pat;
    stall_left = 0;
    style      = 0;
    style_left = 0;
    pat        = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      pat++;
      if (stall_left > 0) begin
        stall_left--;
        report_ch.ready = 1'b0;
      end else begin
        case (style)
          0: report_ch.ready = 1'b1;
          1: report_ch.ready = 1'($urandom_range(0, 1));
          2: report_ch.ready = ($urandom_range(0, 7) == 0);
          default: report_ch.ready = ((pat % 5) < 3);
        endcase
      end
    end
  end

  task automatic send_frame(input frame_t f);
    int gap;
    sgr_result_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        frame_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    frame_ch.sample_0     = f.smp[0];
    frame_ch.sample_1     = f.smp[1];
    frame_ch.sample_2     = f.smp[2];
    frame_ch.sample_3     = f.smp[3];
    frame_ch.sample_4     = f.smp[4];
    frame_ch.sample_5     = f.smp[5];
    frame_ch.sample_6     = f.smp[6];
    frame_ch.sample_7     = f.smp[7];
    frame_ch.sample_8     = f.smp[8];
    frame_ch.sample_9     = f.smp[9];
    frame_ch.timestamp_us = f.ts;
    frame_ch.valid        = 1'b1;
    do @(posedge clk); while (!frame_ch.ready);
    want = predict_report(f);
    reports_pending = {reports_pending, want};
    items_sent++;
  endtask

  // Samples land above or below each position's threshold as the mask says;
  // positions whose threshold can never or always be met ignore it.
  function automatic frame_t make_frame(input logic [9:0] mask, input logic [TIME_W-1:0] ts);
    frame_t f;
    f.ts = ts;
    for (int i = 0; i < 10; i++) begin
      if (mask[i] && lit_level[i] <= 255) f.smp[i] = 8'($urandom_range(lit_level[i], 255));
      else if (lit_level[i] > 0) f.smp[i] = 8'($urandom_range(0, lit_level[i] - 1));
      else f.smp[i] = 8'($urandom_range(0, 255));
    end
    return f;
  endfunction

  function automatic frame_t flat_frame(input logic [7:0] v, input logic [TIME_W-1:0] ts);
    frame_t f;
    f.ts = ts;
    for (int i = 0; i < 10; i++) f.smp[i] = v;
    return f;
  endfunction

  task automatic advance_ts();
    if ($urandom_range(0, 63) == 0) ts_now = ts_now + TIME_W'($urandom);
    else ts_now = ts_now + TIME_W'($urandom_range(0, ts_step_max));
  endtask

  task automatic send_mask(input logic [9:0] mask);
    advance_ts();
    send_frame(make_frame(mask, ts_now));
  endtask

  task automatic send_noise();
    frame_t f;
    advance_ts();
    f.ts = ts_now;
    for (int i = 0; i < 10; i++) f.smp[i] = 8'($urandom_range(0, 255));
    send_frame(f);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    frame_ch.valid = 1'b0;
    burst_left = 0;
    while (reports_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      REG_ARM_COUNT:    cfg_arm   = data[CNT_W-1:0];
      REG_TRACK_COUNT:  cfg_track = data[CNT_W-1:0];
      REG_DELTA_TENTHS: cfg_delta = data[CNT_W-1:0];
      default:          cfg_hold  = data[HOLD_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Four-bit registers get random upper bits, which the block must drop.
  task automatic write_count(input logic [1:0] idx, input logic [CNT_W-1:0] v);
    logic [JUNK_W-1:0] junk;
    junk = JUNK_W'($urandom);
    write_reg(idx, {junk, v});
  endtask

  // A blob of lit samples slides from one place to another, then drops away.
  task automatic run_gesture();
    int w, p0, p1, n, lo, pos, m;
    logic [9:0] mask;
    lo = (cfg_track >= 1 && cfg_track <= 10 && $urandom_range(0, 3) != 0) ? cfg_track : 1;
    w  = lo + $urandom_range(0, (10 - lo) / 2);
    p0 = $urandom_range(0, 10 - w);
    p1 = $urandom_range(0, 10 - w);
    n  = $urandom_range(2, 6);
    repeat ($urandom_range(0, 2)) send_mask('0);
    for (int k = 0; k < n; k++) begin
      pos  = p0 + ((p1 - p0) * k) / (n - 1);
      m    = ((1 << w) - 1) << pos;
      mask = m[9:0];
      if ($urandom_range(0, 5) == 0) mask[4'($urandom_range(0, 9))] ^= 1'b1;
      send_mask(mask);
    end
    repeat ($urandom_range(1, 3)) send_mask('0);
    repeat ($urandom_range(0, 8)) send_mask('0);
  endtask

  task automatic run_random_phase(input int count);
    int start;
    start = items_sent;
    ts_now[47:16] = $urandom;
    ts_now[15:0]  = 16'($urandom);
    ts_step_max   = cfg_hold / 6 + 500;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 9))
        7, 8: repeat ($urandom_range(1, 4)) send_noise();
        9: begin
          repeat ($urandom_range(1, 3)) send_mask(10'($urandom_range(0, 1023)));
          send_mask('0);
        end
        default: run_gesture();
      endcase
    end
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return 1;
      3, 4:    return CNT_W'($urandom_range(2, 4));
      5:       return 10;
      6:       return 0;
      7:       return CNT_W'($urandom_range(11, 15));
      default: return CNT_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic configure_phase(input int ph);
    logic [CNT_W-1:0]  arm, track, delta;
    logic [HOLD_W-1:0] hold;
    case (ph)
      0: begin arm = 1;  track = 1;  delta = 0;  hold = 0;  end
      1: begin arm = 10; track = 10; delta = 10; hold = '1; end
      2: begin arm = 15; track = 12; delta = 15; hold = 300000; end
      default: begin
        arm   = pick_count();
        track = pick_count();
        case ($urandom_range(0, 5))
          0: delta = 0;
          1: delta = 10;
          2: delta = CNT_W'($urandom_range(11, 15));
          default: delta = CNT_W'($urandom_range(1, 9));
        endcase
        case ($urandom_range(0, 5))
          0: hold = 0;
          1: hold = '1;
          2: hold = 300000;
          3: hold = HOLD_W'($urandom_range(1, 100));
          default: hold = HOLD_W'($urandom);
        endcase
      end
    endcase
    write_count(REG_ARM_COUNT, arm);
    write_count(REG_TRACK_COUNT, track);
    write_count(REG_DELTA_TENTHS, delta);
    write_reg(REG_HOLDOFF_US, hold);
  endtask

  // Default settings: one swipe down, one up, holdoff with a timestamp that
  // lies behind the holdoff end, and all-dark and all-bright frames.
  task automatic test_directed_swipes();
    logic [TIME_W-1:0] end_ts;
    send_frame(flat_frame(8'd0, 48'd0));
    send_frame(make_frame(10'h007, 48'd1000));
    send_frame(make_frame(10'h007, 48'd2000));
    send_frame(make_frame(10'h380, 48'd3000));
    send_frame(make_frame(10'h000, 48'd4000));
    send_frame(flat_frame(8'd255, TS_MAX));
    send_frame(make_frame(10'h000, 48'd303999));
    send_frame(make_frame(10'h000, 48'd304000));
    send_frame(make_frame(10'h380, 48'd305000));
    send_frame(make_frame(10'h380, 48'd306000));
    send_frame(make_frame(10'h007, 48'd307000));
    send_frame(make_frame(10'h000, 48'd308000));
    end_ts = 48'd308000 + HOLDOFF_US_RST + 1;
    send_frame(flat_frame(8'd255, end_ts));
  endtask

  // Zero arm count arms on an empty frame; once it is raised again, the
  // swipe is judged against an empty starting centroid.
  task automatic test_empty_centroid();
    drain_reports();
    write_count(REG_ARM_COUNT, 4'd0);
    send_frame(make_frame(10'h000, 48'd400000));
    send_frame(make_frame(10'h00F, 48'd401000));
    send_frame(make_frame(10'h0F0, 48'd402000));
    drain_reports();
    write_count(REG_ARM_COUNT, 4'd1);
    send_frame(make_frame(10'h000, 48'd403000));
  endtask

  // The holdoff end wraps past the top of the timestamp range.
  task automatic test_time_wrap();
    drain_reports();
    write_reg(REG_HOLDOFF_US, 24'd1000);
    send_frame(make_frame(10'h000, 48'd20000000));
    send_frame(make_frame(10'h00F, TS_MAX - 48'd2999));
    send_frame(make_frame(10'h00F, TS_MAX - 48'd1999));
    send_frame(make_frame(10'h3C0, TS_MAX - 48'd999));
    send_frame(make_frame(10'h000, TS_MAX - 48'd499));
    send_frame(make_frame(10'h000, TS_MAX - 48'd99));
    send_frame(make_frame(10'h000, 48'd400));
    send_frame(make_frame(10'h000, 48'd500));
  endtask

  // The receiver holds off long enough for the block to fill and stall
  // its input, then the sender waits for every word to come back.
  task automatic test_backpressure();
    drain_reports();
    ts_now = 48'd1000000;
    ts_step_max = cfg_hold / 6 + 500;
    hold_request = 400;
    repeat (3) run_gesture();
    drain_reports();
  endtask

  task automatic test_random_phases();
    int ph;
    ph = 0;
    while (items_sent < ITEMS_TARGET) begin
      drain_reports();
      configure_phase(ph);
      run_random_phase(PHASE_ITEMS);
      ph++;
    end
    phases_run = ph;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    items_sent   = 0;
    reports_seen = 0;
    swipes_down  = 0;
    swipes_up    = 0;
    phases_run   = 0;
    burst_left   = 0;
    hold_request = 0;
    cycle_cnt    = 0;
    ts_now       = '0;
    ts_step_max  = 1000;
    frame_ch.valid        = 1'b0;
    frame_ch.sample_0     = '0;
    frame_ch.sample_1     = '0;
    frame_ch.sample_2     = '0;
    frame_ch.sample_3     = '0;
    frame_ch.sample_4     = '0;
    frame_ch.sample_5     = '0;
    frame_ch.sample_6     = '0;
    frame_ch.sample_7     = '0;
    frame_ch.sample_8     = '0;
    frame_ch.sample_9     = '0;
    frame_ch.timestamp_us = '0;
    gesture_reset();
    // Lowest lit brightness per position; 256 means never lit.
    for (int i = 0; i < 10; i++) begin
      lit_level[i] = 256;
      for (int s = 255; s >= 0; s--) begin
        if (sample_lit(i, 8'(s))) lit_level[i] = s;
      end
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_swipes();
    test_empty_centroid();
    test_time_wrap();
    test_backpressure();
    test_random_phases();
    drain_reports();

    $display("covered %0d frames over %0d random register settings plus directed cases",
             items_sent, phases_run);
    $display("swipes seen: %0d down, %0d up; %0d report words checked",
             swipes_down, swipes_up, reports_seen);
    if (errors == 0) begin
      $display("swipe_gesture_recognizer regression: pass");
    end else begin
      $display("swipe_gesture_recognizer regression: fail");
    end
    $finish;
  end

endmodule
